/* design/spd_pkg.sv */
package spd_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'hED;
  localparam logic [7:0] STATUS_BYTE = 8'h2A;
  localparam logic [7:0] MIN_LENGTH  = 8'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam logic [1:0] FS_GOOD    = 2'd0;
  localparam logic [1:0] FS_BAD_SUM = 2'd1;
  localparam logic [1:0] FS_BAD_LEN = 2'd2;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_ROUTE   = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

endpackage

/* design/spd_if.sv */
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface spd_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [1:0] route;
  logic [1:0] frame_status;
  logic       status_frame;
  logic       last;

  modport source (output valid, output result_kind, output data_byte, output byte_index,
                  output route, output frame_status, output status_frame, output last,
                  input ready);
  modport sink   (input valid, input result_kind, input data_byte, input byte_index,
                  input route, input frame_status, input status_frame, input last,
                  output ready);
endinterface

/* design/serial_packet_deframer_core.sv */
// Serial packet deframer.
//
// rx carries one received serial byte per item. The block hunts for the sync
// byte 0xED, then reads the total length byte and the routing byte (top two
// bits kept as route). Each payload byte goes out on res as a payload item
// (result_kind 0) with its index; the checksum byte closes the frame with an
// end report (result_kind 1, last 1) carrying good / bad checksum and the
// status-frame flag. A length byte below four ends the frame at once with a
// bad-length report. Header bytes and hunted bytes give no item on res.
//
// Output: each result is registered and appears on res in the cycle after its
// byte is accepted. Throughput: one byte per cycle while res is not stalled; the
// loops are the 8-bit rotate-and-add checksum, the payload count and the phase.
// Reset (synchronous, rst high) returns to hunting, clears the checksum and
// counters and empties the result register.
// Stall: res holds its item while ready is low; rx keeps accepting as long as
// the result register is empty or being drained in the same cycle.
module serial_packet_deframer_core (
  input  logic             clk,
  input  logic             rst,
  spd_in_if.sink           rx,
  spd_out_if.source        res
);

  spd_pkg::phase_t phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [1:0] route_bits, route_bits_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic       first_is_status, first_is_status_next;

  // Result produced by the byte being accepted this cycle.
  logic       emit;
  logic       kind;
  logic [7:0] data_out;
  logic [7:0] index_out;
  logic [1:0] route_out;
  logic [1:0] status_out;
  logic       sflag_out;

  logic       accept;
  logic [7:0] b;
  logic [7:0] count_inc;

  function automatic logic [7:0] sum_add(input logic [7:0] s, input logic [7:0] d);
    sum_add = {s[6:0], s[7]} + d;
  endfunction

  // Take a new byte whenever the result register is free or draining.
  assign rx.ready = !res.valid || res.ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign count_inc = payload_count + 8'd1;

  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    route_bits_next      = route_bits;
    payload_count_next   = payload_count;
    running_sum_next     = running_sum;
    first_is_status_next = first_is_status;
    emit       = 1'b0;
    kind       = spd_pkg::KIND_PAYLOAD;
    data_out   = 8'd0;
    index_out  = 8'd0;
    route_out  = 2'd0;
    status_out = spd_pkg::FS_GOOD;
    sflag_out  = 1'b0;
    case (phase)
      spd_pkg::PH_LENGTH: begin
        frame_length_next = b;
        if (b < spd_pkg::MIN_LENGTH) begin
          // Short frame: report it right away and go back to hunting.
          phase_next       = spd_pkg::PH_HUNT;
          running_sum_next = 8'd0;
          emit       = 1'b1;
          kind       = spd_pkg::KIND_REPORT;
          status_out = spd_pkg::FS_BAD_LEN;
        end else begin
          running_sum_next = sum_add(running_sum, b);
          phase_next       = spd_pkg::PH_ROUTE;
        end
      end
      spd_pkg::PH_ROUTE: begin
        route_bits_next      = b[7:6];
        running_sum_next     = sum_add(running_sum, b);
        payload_count_next   = 8'd0;
        first_is_status_next = 1'b0;
        phase_next = (frame_length == spd_pkg::MIN_LENGTH) ? spd_pkg::PH_CHECK
                                                           : spd_pkg::PH_PAYLOAD;
      end
      spd_pkg::PH_PAYLOAD: begin
        if (payload_count == 8'd0 && b == spd_pkg::STATUS_BYTE) begin
          first_is_status_next = 1'b1;
        end
        running_sum_next   = sum_add(running_sum, b);
        payload_count_next = count_inc;
        // Length is at least five here, so the subtraction cannot wrap.
        if (count_inc >= frame_length - spd_pkg::MIN_LENGTH) begin
          phase_next = spd_pkg::PH_CHECK;
        end
        emit      = 1'b1;
        data_out  = b;
        index_out = payload_count;
        route_out = route_bits;
      end
      spd_pkg::PH_CHECK: begin
        phase_next       = spd_pkg::PH_HUNT;
        running_sum_next = 8'd0;
        emit       = 1'b1;
        kind       = spd_pkg::KIND_REPORT;
        route_out  = route_bits;
        status_out = (b == running_sum) ? spd_pkg::FS_GOOD : spd_pkg::FS_BAD_SUM;
        sflag_out  = first_is_status && !route_bits[1];
      end
      default: begin
        // Hunting: drop everything but the sync byte.
        if (b == spd_pkg::SYNC_BYTE) begin
          running_sum_next = sum_add(8'd0, b);
          phase_next       = spd_pkg::PH_LENGTH;
        end else begin
          phase_next = spd_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // Frame state advances only on accepted bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= spd_pkg::PH_HUNT;
      frame_length    <= 8'd0;
      route_bits      <= 2'd0;
      payload_count   <= 8'd0;
      running_sum     <= 8'd0;
      first_is_status <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      frame_length    <= frame_length_next;
      route_bits      <= route_bits_next;
      payload_count   <= payload_count_next;
      running_sum     <= running_sum_next;
      first_is_status <= first_is_status_next;
    end
  end

  // Result register: load on an emitting byte, clear when drained, hold on stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept) begin
      res.valid <= emit;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res.result_kind  <= kind;
      res.data_byte    <= data_out;
      res.byte_index   <= index_out;
      res.route        <= route_out;
      res.frame_status <= status_out;
      res.status_frame <= sflag_out;
      res.last         <= kind;
    end
  end

endmodule

/* design/spd_checker.sv */
module spd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       result_kind,
  input logic [7:0] data_byte,
  input logic [7:0] byte_index,
  input logic [1:0] frame_status,
  input logic       status_frame,
  input logic       last
);

  // A stalled item holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(byte_index)
                                && $stable(result_kind) && $stable(frame_status))
    else $error("stalled item changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last == result_kind)
    else $error("last does not match result kind");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == spd_pkg::KIND_PAYLOAD |->
      frame_status == spd_pkg::FS_GOOD && !status_frame)
    else $error("payload item carries report fields");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == spd_pkg::KIND_REPORT |->
      data_byte == 8'd0 && byte_index == 8'd0 && frame_status != 2'd3)
    else $error("malformed end report");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_status == spd_pkg::FS_BAD_LEN |-> !status_frame)
    else $error("bad-length report flagged as status frame");

endmodule

bind serial_packet_deframer_core spd_checker u_spd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .result_kind  (res.result_kind),
  .data_byte    (res.data_byte),
  .byte_index   (res.byte_index),
  .frame_status (res.frame_status),
  .status_frame (res.status_frame),
  .last         (res.last)
);
